// ===== design/vmic_pkg.sv =====
// ----------------------------------------------------------------------------
// vmic_pkg
// Shared codes, request/result types and a command helper for the valve mode and
// interlock controller.
// ----------------------------------------------------------------------------
package vmic_pkg;

  localparam int MODE_W = 3;
  localparam int CMD_W  = 2;
  localparam int POS_W  = 2;
  localparam int DRV_W  = 3;

  // Mode codes
  localparam logic [MODE_W-1:0] MODE_REMOTE = 3'd0;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_OTHER  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ALGO   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_REPAIR = 3'd4;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CLOSE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_HOLD  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OPEN  = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

  // Position codes
  localparam logic [POS_W-1:0] POS_CLOSED  = 2'd0;
  localparam logic [POS_W-1:0] POS_BETWEEN = 2'd1;
  localparam logic [POS_W-1:0] POS_OPEN    = 2'd2;

  typedef struct packed {
    logic              interlock;
    logic              closed_switch;
    logic              open_switch;
    logic              permissive;
    logic              repair;
    logic              local_control;
    logic              local_open;
    logic              local_close;
    logic [CMD_W-1:0]  setpoint_in;
    logic [MODE_W-1:0] mode_request;
    logic [CMD_W-1:0]  command_request;
  } item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CMD_W-1:0]  command;
    logic              algorithm;
    logic              handover;
    logic              lat_interlock;
    logic              lat_closed;
    logic              lat_open;
    logic [CMD_W-1:0]  lat_setpoint;
    logic              lat_local_open;
    logic              lat_local_close;
    logic [DRV_W-1:0]  drive;
    logic [POS_W-1:0]  position;
    logic              fault;
  } state_t;

  typedef struct packed {
    logic              drive_close;
    logic              drive_hold;
    logic              drive_open;
    logic [POS_W-1:0]  position;
    logic              fault;
    logic              interlock_indicator;
    logic              interlock_active;
    logic [CMD_W-1:0]  setpoint_out;
    logic [MODE_W-1:0] mode_now;
    logic [CMD_W-1:0]  command_now;
    logic              algorithm_on;
  } result_t;

  // Code three means hold
  function automatic logic [CMD_W-1:0] clamp_cmd(input logic [CMD_W-1:0] v);
    clamp_cmd = (v == CMD_NONE) ? CMD_HOLD : v;
  endfunction

endpackage

// ===== design/valve_mode_interlock_controller_core.sv =====
// ----------------------------------------------------------------------------
// valve_mode_interlock_controller_core
// Valve mode and interlock controller: one result per control tick.
// ----------------------------------------------------------------------------
// Each accepted request is one control tick. It sits in the input register
// while the tick logic updates the controller state and fills the result
// register once that register has room. A request therefore passes through
// the input register and then the result register, and a new request is
// taken every cycle while out_stall is low. The rate is set by the single
// state update per cycle in the tick logic. The interlock position register
// is written through cfg_valid/cfg_ready (always ready) and should only be
// written while no tick is in flight.
module valve_mode_interlock_controller_core (
  input  logic                         clk,
  input  logic                         rst_n,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vmic_pkg::CMD_W-1:0]   cfg_interlock_position,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_interlock,
  input  logic                         in_closed_switch,
  input  logic                         in_open_switch,
  input  logic                         in_permissive,
  input  logic                         in_repair,
  input  logic                         in_local_control,
  input  logic                         in_local_open,
  input  logic                         in_local_close,
  input  logic [vmic_pkg::CMD_W-1:0]   in_setpoint_in,
  input  logic [vmic_pkg::MODE_W-1:0]  in_mode_request,
  input  logic [vmic_pkg::CMD_W-1:0]   in_command_request,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_drive_close,
  output logic                         out_drive_hold,
  output logic                         out_drive_open,
  output logic [vmic_pkg::POS_W-1:0]   out_position,
  output logic                         out_fault,
  output logic                         out_interlock_indicator,
  output logic                         out_interlock_active,
  output logic [vmic_pkg::CMD_W-1:0]   out_setpoint_out,
  output logic [vmic_pkg::MODE_W-1:0]  out_mode_now,
  output logic [vmic_pkg::CMD_W-1:0]   out_command_now,
  output logic                         out_algorithm_on
);

  localparam vmic_pkg::state_t STATE_RST = '{
    mode:            vmic_pkg::MODE_REMOTE,
    command:         vmic_pkg::CMD_HOLD,
    algorithm:       1'b0,
    handover:        1'b0,
    lat_interlock:   1'b0,
    lat_closed:      1'b0,
    lat_open:        1'b0,
    lat_setpoint:    vmic_pkg::CMD_CLOSE,
    lat_local_open:  1'b0,
    lat_local_close: 1'b0,
    drive:           '0,
    position:        vmic_pkg::POS_CLOSED,
    fault:           1'b0
  };

  vmic_pkg::item_t                in_item;
  vmic_pkg::item_t                item;
  logic                           item_valid;
  vmic_pkg::state_t               state_r;
  vmic_pkg::state_t               state_nxt;
  vmic_pkg::state_t               tick_state;
  vmic_pkg::result_t              tick_res;
  vmic_pkg::result_t              res;
  logic [vmic_pkg::CMD_W-1:0]     ilock_pos_r;
  logic [vmic_pkg::CMD_W-1:0]     ilock_pos_nxt;
  logic                           out_free;
  logic                           fire;

  assign cfg_ready = 1'b1;

  assign in_item.interlock       = in_interlock;
  assign in_item.closed_switch   = in_closed_switch;
  assign in_item.open_switch     = in_open_switch;
  assign in_item.permissive      = in_permissive;
  assign in_item.repair          = in_repair;
  assign in_item.local_control   = in_local_control;
  assign in_item.local_open      = in_local_open;
  assign in_item.local_close     = in_local_close;
  assign in_item.setpoint_in     = in_setpoint_in;
  assign in_item.mode_request    = in_mode_request;
  assign in_item.command_request = in_command_request;

  // advance the held request when the result register has room
  assign fire = item_valid && out_free;

  vmic_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .take       (fire),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  vmic_tick u_tick (
    .item      (item),
    .st        (state_r),
    .ilock_pos (ilock_pos_r),
    .st_nxt    (tick_state),
    .res       (tick_res)
  );

  assign state_nxt     = fire ? tick_state : state_r;
  assign ilock_pos_nxt = (cfg_valid && cfg_ready) ? cfg_interlock_position : ilock_pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_RST;
      ilock_pos_r <= vmic_pkg::CMD_CLOSE;
    end else begin
      state_r     <= state_nxt;
      ilock_pos_r <= ilock_pos_nxt;
    end
  end

  vmic_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .res       (tick_res),
    .out_stall (out_stall),
    .free      (out_free),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_drive_close         = res.drive_close;
  assign out_drive_hold          = res.drive_hold;
  assign out_drive_open          = res.drive_open;
  assign out_position            = res.position;
  assign out_fault               = res.fault;
  assign out_interlock_indicator = res.interlock_indicator;
  assign out_interlock_active    = res.interlock_active;
  assign out_setpoint_out        = res.setpoint_out;
  assign out_mode_now            = res.mode_now;
  assign out_command_now         = res.command_now;
  assign out_algorithm_on        = res.algorithm_on;

endmodule

// ===== design/vmic_in_stage.sv =====
// ----------------------------------------------------------------------------
// vmic_in_stage
// Input register: holds one request until the tick logic consumes it.
// ----------------------------------------------------------------------------
module vmic_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  vmic_pkg::item_t in_item,
  input  logic            take,
  output logic            in_stall,
  output logic            item_valid,
  output vmic_pkg::item_t item
);

  logic            valid_r;
  logic            valid_nxt;
  vmic_pkg::item_t item_r;
  logic            load;

  // hold off a new request only while the held one cannot move on
  assign in_stall  = valid_r && !take;
  assign load      = in_valid && !in_stall;
  assign valid_nxt = load ? 1'b1 : (take ? 1'b0 : valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// ===== design/vmic_tick.sv =====
// ----------------------------------------------------------------------------
// vmic_tick
// One control tick: operator writes, repair, latching, algorithm hand-over,
// local buttons, remote/auto link, interlock override, position, drive and fault.
// ----------------------------------------------------------------------------
module vmic_tick (
  input  vmic_pkg::item_t             item,
  input  vmic_pkg::state_t            st,
  input  logic [vmic_pkg::CMD_W-1:0]  ilock_pos,
  output vmic_pkg::state_t            st_nxt,
  output vmic_pkg::result_t           res
);

  vmic_pkg::state_t s;
  logic             ind;
  logic             act;

  always_comb begin
    s = st;

    if (item.mode_request <= vmic_pkg::MODE_ALGO) begin
      s.mode = item.mode_request;
    end
    if (item.command_request <= vmic_pkg::CMD_OPEN) begin
      s.command = item.command_request;
    end

    // indicators see the interlock latched on an earlier tick
    ind = st.lat_interlock;
    act = st.lat_interlock && !st.algorithm;

    if (!item.permissive && !st.algorithm) begin
      // ignored tick: operator writes only
    end else if (item.repair) begin
      s.mode    = vmic_pkg::MODE_REPAIR;
      s.command = vmic_pkg::CMD_HOLD;
    end else begin
      s.lat_interlock   = item.interlock;
      s.lat_closed      = item.closed_switch;
      s.lat_open        = item.open_switch;
      s.lat_setpoint    = vmic_pkg::clamp_cmd(item.setpoint_in);
      s.lat_local_open  = item.local_open;
      s.lat_local_close = item.local_close;

      if (s.mode == vmic_pkg::MODE_REPAIR) begin
        s.algorithm = 1'b1;
        s.mode      = vmic_pkg::MODE_ALGO;
      end
      if (!s.algorithm && s.mode == vmic_pkg::MODE_ALGO) begin
        s.mode = vmic_pkg::MODE_REMOTE;
      end
      if ((s.mode == vmic_pkg::MODE_REMOTE || s.mode == vmic_pkg::MODE_AUTO) &&
          s.handover) begin
        s.handover  = 1'b0;
        s.algorithm = 1'b0;
      end

      if (s.algorithm && !s.handover) begin
        // hand over to the algorithm; drive outputs stay as they were
        s.mode     = vmic_pkg::MODE_ALGO;
        s.handover = 1'b1;
      end else begin
        if (item.local_control) begin
          if (s.lat_local_open) begin
            s.command = vmic_pkg::CMD_OPEN;
          end else if (s.lat_local_close) begin
            s.command = vmic_pkg::CMD_CLOSE;
          end else begin
            s.command = vmic_pkg::CMD_HOLD;
          end
        end

        if (s.mode == vmic_pkg::MODE_REMOTE) begin
          s.lat_setpoint = s.command;
        end else if (s.mode == vmic_pkg::MODE_AUTO) begin
          s.command = s.lat_setpoint;
        end

        if (s.lat_interlock && !s.algorithm) begin
          s.mode    = vmic_pkg::MODE_REMOTE;
          s.command = vmic_pkg::clamp_cmd(ilock_pos);
        end

        if (s.lat_closed && !s.lat_open) begin
          s.position = vmic_pkg::POS_CLOSED;
        end else if (!s.lat_closed && s.lat_open) begin
          s.position = vmic_pkg::POS_OPEN;
        end else begin
          s.position = vmic_pkg::POS_BETWEEN;
        end

        s.drive = vmic_pkg::DRV_W'(1) << s.command;
        s.fault = (s.position != s.command);
      end
    end

    st_nxt = s;

    res.drive_close         = s.drive[0];
    res.drive_hold          = s.drive[1];
    res.drive_open          = s.drive[2];
    res.position            = s.position;
    res.fault               = s.fault;
    res.interlock_indicator = ind;
    res.interlock_active    = act;
    res.setpoint_out        = s.lat_setpoint;
    res.mode_now            = s.mode;
    res.command_now         = s.command;
    res.algorithm_on        = s.algorithm;
  end

endmodule

// ===== design/vmic_out_stage.sv =====
// ----------------------------------------------------------------------------
// vmic_out_stage
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module vmic_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  vmic_pkg::result_t res,
  input  logic              out_stall,
  output logic              free,
  output logic              out_valid,
  output vmic_pkg::result_t out_res
);

  logic              valid_r;
  logic              valid_nxt;
  vmic_pkg::result_t res_r;

  // room when empty or when the held result leaves this cycle
  assign free      = !valid_r || !out_stall;
  assign valid_nxt = load ? 1'b1 : (out_stall ? valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
